// File: design/cp15_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CP15 register file package
// Request and response types, decode codes and the transfer decoder.
// ----------------------------------------------------------------------------
package cp15_pkg;

  localparam int NumRegs  = 19;
  localparam int IdxW     = $clog2(NumRegs);
  localparam int PidShift = 25;

  localparam logic [IdxW-1:0] R_SCTLR  = IdxW'(0);
  localparam logic [IdxW-1:0] R_ACTLR  = IdxW'(1);
  localparam logic [IdxW-1:0] R_CPACR  = IdxW'(2);
  localparam logic [IdxW-1:0] R_CSSELR = IdxW'(3);
  localparam logic [IdxW-1:0] R_TTBR0  = IdxW'(4);
  localparam logic [IdxW-1:0] R_TTBR1  = IdxW'(5);
  localparam logic [IdxW-1:0] R_TTBCR  = IdxW'(6);
  localparam logic [IdxW-1:0] R_DACR   = IdxW'(7);
  localparam logic [IdxW-1:0] R_DFSR   = IdxW'(8);
  localparam logic [IdxW-1:0] R_IFSR   = IdxW'(9);
  localparam logic [IdxW-1:0] R_DFAR   = IdxW'(10);
  localparam logic [IdxW-1:0] R_IFAR   = IdxW'(11);
  localparam logic [IdxW-1:0] R_L2AUX  = IdxW'(12);
  localparam logic [IdxW-1:0] R_PRRR   = IdxW'(13);
  localparam logic [IdxW-1:0] R_NMRR   = IdxW'(14);
  localparam logic [IdxW-1:0] R_CTXID  = IdxW'(15);

  // Configuration register indexes
  localparam logic [1:0] CFG_FEATURES = 2'd0;
  localparam logic [1:0] CFG_MAIN_ID  = 2'd1;
  localparam logic [1:0] CFG_CTYPE    = 2'd2;
  localparam logic [1:0] CFG_CLEVEL   = 2'd3;

  typedef enum logic [2:0] {
    ST_DONE, ST_UND, ST_UNIMP, ST_CACHE, ST_TLB, ST_CCSIDR
  } status_t;

  // What the execute cycle does with the decoded transfer
  typedef enum logic [2:0] {
    K_NONE,   // nothing beyond the status
    K_MEM,    // plain register read or write
    K_CTX,    // write that flags a context flush on change
    K_CONST,  // read of an identification constant
    K_PID     // FCSE PID access
  } kind_t;

  typedef enum logic [1:0] { C_MIDR, C_CTR, C_CLIDR } csel_t;

  typedef enum logic { S_IDLE, S_EXEC } state_t;

  typedef struct packed {
    logic        is_read;
    logic [3:0]  primary_reg;
    logic [2:0]  opcode_one;
    logic [3:0]  secondary_reg;
    logic [2:0]  opcode_two;
    logic [31:0] write_value;
    logic        mmu_active;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_data;
    logic        read_valid;
    logic        flush_context;
    logic        flush_all_tlbs;
    logic        control_written;
  } rsp_t;

  typedef struct packed {
    status_t         status;
    kind_t           kind;
    logic [IdxW-1:0] idx;
    csel_t           csel;
    logic            ctl;
    logic            tlb;
  } dec_t;

  // Decode one transfer against the feature flags.
  function automatic dec_t decode(req_t r, logic [5:0] ff);
    dec_t       d;
    logic       v6, v7, aux, sec, l2, dbg, rd, is_alt;
    logic [2:0] op1, op2, sel, alt;
    logic [3:0] crm;
    v6  = ff[0];
    v7  = ff[1];
    aux = ff[2];
    sec = ff[3];
    l2  = ff[4];
    dbg = ff[5];
    rd  = r.is_read;
    op1 = r.opcode_one;
    op2 = r.opcode_two;
    crm = r.secondary_reg;
    d.status = ST_DONE;
    d.kind   = K_NONE;
    d.idx    = R_SCTLR;
    d.csel   = C_MIDR;
    d.ctl    = 1'b0;
    d.tlb    = 1'b0;
    sel      = 3'd0;
    alt      = 3'd0;
    is_alt   = 1'b0;
    case (r.primary_reg)
      4'd0: begin
        if (v7 && op1 == 3'd1 && crm == 4'd0 && rd) begin
          if (op2 == 3'd0) begin
            d.status = ST_CCSIDR;
            d.kind   = K_MEM;
            d.idx    = R_CSSELR;
          end else if (op2 == 3'd1) begin
            d.kind = K_CONST;
            d.csel = C_CLIDR;
          end else begin
            d.status = ST_UND;
          end
        end else if (v7 && op1 == 3'd2 && crm == 4'd0 && op2 == 3'd0) begin
          d.kind = K_MEM;
          d.idx  = R_CSSELR;
        end else if (op1 == 3'd0 && (crm == 4'd0 || !v6) && rd && op2 <= 3'd1) begin
          d.kind = K_CONST;
          d.csel = (op2 == 3'd0) ? C_MIDR : C_CTR;
        end else begin
          d.status = ST_UND;
        end
      end
      4'd1: begin
        sel = (aux || v6) ? op2 : 3'd0;
        if (op1 == 3'd0 && crm == 4'd1 && sec) begin
          d.status = ST_UNIMP;
        end else if (op1 != 3'd0 || (crm != 4'd0 && v6)) begin
          d.status = ST_UND;
        end else if (sel == 3'd0) begin
          d.kind = K_MEM;
          d.idx  = R_SCTLR;
          d.ctl  = !rd;
        end else if (sel == 3'd1 && aux) begin
          d.kind = K_MEM;
          d.idx  = R_ACTLR;
        end else if (sel == 3'd2 && v6) begin
          d.kind = K_MEM;
          d.idx  = R_CPACR;
        end else begin
          d.status = ST_UND;
        end
      end
      4'd2: begin
        if (v6 && (op2 == 3'd1 || op2 == 3'd2)) begin
          d.kind = K_MEM;
          d.idx  = (op2 == 3'd1) ? R_TTBR1 : R_TTBCR;
        end else begin
          d.kind = rd ? K_MEM : K_CTX;
          d.idx  = R_TTBR0;
        end
      end
      4'd3: begin
        d.kind = K_MEM;
        d.idx  = R_DACR;
        d.tlb  = !rd;
      end
      4'd5, 4'd6: begin
        alt    = (r.primary_reg == 4'd5) ? 3'd1 : 3'd2;
        is_alt = (op2 == alt) && v6;
        if (op1 != 3'd0 || (crm != 4'd0 && v6) || (op2 != 3'd0 && !is_alt && v6)) begin
          d.status = ST_UND;
        end else begin
          d.kind = K_MEM;
          if (r.primary_reg == 4'd5) d.idx = is_alt ? R_IFSR : R_DFSR;
          else d.idx = is_alt ? R_IFAR : R_DFAR;
        end
      end
      4'd7: d.status = ST_CACHE;
      4'd8: d.status = ST_TLB;
      4'd9: begin
        if (l2 && op1 == 3'd1 && crm == 4'd0 && op2 == 3'd2) begin
          d.kind = K_MEM;
          d.idx  = R_L2AUX;
        end else begin
          d.status = ST_UND;
        end
      end
      4'd10: begin
        if (v6 && op1 == 3'd0 && crm == 4'd2 && op2 <= 3'd1) begin
          d.kind = K_MEM;
          d.idx  = (op2 == 3'd0) ? R_PRRR : R_NMRR;
        end else begin
          d.status = ST_UND;
        end
      end
      4'd12: d.status = sec ? ST_UNIMP : ST_UND;
      4'd13: begin
        if (v6 && op2 >= 3'd1 && op2 <= 3'd4) begin
          d.idx  = R_CTXID + IdxW'(op2 - 3'd1);
          d.kind = (!rd && op2 == 3'd1) ? K_CTX : K_MEM;
        end else begin
          d.kind = K_PID;
        end
      end
      4'd15: begin
        if (!(dbg && !rd && op1 == 3'd0 && crm == 4'd2 && op2 == 3'd4))
          d.status = ST_UNIMP;
      end
      default: d.status = ST_UND;
    endcase
    return d;
  endfunction

endpackage

// File: design/cp15_system_register_file.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CP15 system register file
// Decodes coprocessor register transfers and keeps the system registers in
// a small synchronous memory.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                 | payload
//  request   | in        | start and not busy        | req (req_t)
//  response  | out       | result_valid, one cycle   | rsp (rsp_t)
//  config    | in        | cfg_we                    | cfg_index, cfg_data
//
// A request passes through an accept and an execute cycle: the accept cycle
// decodes it and reads the register memory, the execute cycle forms the
// response and writes back. busy is high during the execute cycle, so no new
// request is taken until the memory read, modify and write of the last one
// is through. The response appears the cycle after execute, for one cycle;
// the receiver cannot stall. Synchronous reset clears per-entry valid bits,
// so every register reads as zero until written; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cp15_system_register_file (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  cp15_pkg::req_t  req,
  output logic            result_valid,
  output cp15_pkg::rsp_t  rsp,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data
);
  import cp15_pkg::*;

  // Configuration registers
  logic [5:0]  feature_flags;
  logic [31:0] main_id_value;
  logic [31:0] cache_type_value;
  logic [31:0] cache_level_id_value;

  // Register memory and per-entry valid bits
  logic [31:0]        mem [NumRegs];
  logic [NumRegs-1:0] vld;
  logic [31:0]        mem_q;
  logic               mem_vq;
  logic [6:0]         fcse_pid;

  state_t state, state_next;
  req_t   req_q;
  dec_t   dec_q;
  dec_t   dec_in;

  logic        accept;
  logic        mem_we;
  logic [31:0] cur;
  logic [6:0]  pid_in;
  logic        pid_we;
  rsp_t        rsp_next;

  assign accept = start && (state == S_IDLE);
  assign dec_in = decode(req, feature_flags);
  assign cur    = mem_vq ? mem_q : 32'd0;
  assign pid_in = req_q.write_value[31:PidShift];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      feature_flags        <= '0;
      main_id_value        <= '0;
      cache_type_value     <= '0;
      cache_level_id_value <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FEATURES: feature_flags        <= cfg_data[5:0];
        CFG_MAIN_ID:  main_id_value        <= cfg_data;
        CFG_CTYPE:    cache_type_value     <= cfg_data;
        CFG_CLEVEL:   cache_level_id_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy = 1'b0;
    case (state)
      S_IDLE:  busy = 1'b0;
      S_EXEC:  busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Capture the request and its decode on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
      dec_q <= dec_in;
    end
  end

  // Memory read at accept, write back in execute
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q  <= mem[dec_in.idx];
      mem_vq <= vld[dec_in.idx];
    end
    if (mem_we) mem[dec_q.idx] <= req_q.write_value;
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (mem_we) vld[dec_q.idx] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) fcse_pid <= '0;
    else if (pid_we) fcse_pid <= pid_in;
  end

  // Execute: form the response and the write-back
  always_comb begin
    rsp_next                 = '0;
    rsp_next.status          = dec_q.status;
    rsp_next.control_written = dec_q.ctl;
    rsp_next.flush_all_tlbs  = dec_q.tlb;
    mem_we = 1'b0;
    pid_we = 1'b0;
    if (state == S_EXEC) begin
      case (dec_q.kind)
        K_MEM: begin
          if (dec_q.status == ST_CCSIDR) begin
            rsp_next.read_data = cur;
          end else if (req_q.is_read) begin
            rsp_next.read_data  = cur;
            rsp_next.read_valid = 1'b1;
          end else begin
            mem_we = 1'b1;
          end
        end
        K_CTX: begin
          mem_we = 1'b1;
          rsp_next.flush_context = (cur != req_q.write_value);
        end
        K_CONST: begin
          rsp_next.read_valid = 1'b1;
          case (dec_q.csel)
            C_MIDR:  rsp_next.read_data = main_id_value;
            C_CTR:   rsp_next.read_data = cache_type_value;
            C_CLIDR: rsp_next.read_data = cache_level_id_value;
            default: rsp_next.read_data = '0;
          endcase
        end
        K_PID: begin
          if (req_q.is_read) begin
            rsp_next.read_data  = {fcse_pid, {PidShift{1'b0}}};
            rsp_next.read_valid = 1'b1;
          end else begin
            pid_we = 1'b1;
            rsp_next.flush_context = (pid_in != fcse_pid);
          end
        end
        default: ;
      endcase
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= (state == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) rsp <= rsp_next;
  end

endmodule
